// ===== src/compass_frame_parser_top_defines.svh =====
// ---------------------------------------------------------------------------
// compass frame parser assertion macros
// shared property forms for the parser's concurrent checks
// ---------------------------------------------------------------------------
`ifndef COMPASS_FRAME_PARSER_TOP_DEFINES_SVH
`define COMPASS_FRAME_PARSER_TOP_DEFINES_SVH

// same-cycle implication, disabled while reset is held
`define CFP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is held
`define CFP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/cfp_pkg.sv =====
// ---------------------------------------------------------------------------
// compass frame parser package
// frame constants, byte positions and channel payload types
// ---------------------------------------------------------------------------
package cfp_pkg;

  localparam logic [7:0] HDR0      = 8'h0D;
  localparam logic [7:0] HDR1      = 8'h0A;
  localparam logic [7:0] SUM_EXTRA = 8'h2E;
  localparam logic [7:0] SUM_BASE  = HDR0 + HDR1 + SUM_EXTRA;
  localparam logic [3:0] NIBBLE_MASK = 4'hF;

  // byte positions within a frame
  localparam logic [2:0] POS_HDR0     = 3'd0;
  localparam logic [2:0] POS_HDR1     = 3'd1;
  localparam logic [2:0] POS_HUNDREDS = 3'd2;
  localparam logic [2:0] POS_TENS     = 3'd3;
  localparam logic [2:0] POS_UNITS    = 3'd4;
  localparam logic [2:0] POS_TENTHS   = 3'd6;
  localparam logic [2:0] POS_SUM      = 3'd7;

  localparam int unsigned ANGLE_W   = 11;
  localparam logic [ANGLE_W-1:0] ANGLE_MAX = 11'd1665;

  typedef enum logic [1:0] {
    STATUS_GOOD    = 2'd0,
    STATUS_BAD_HDR = 2'd1,
    STATUS_BAD_SUM = 2'd2
  } cfp_status_e;

  typedef struct packed {
    logic [7:0] rx_byte;
  } cfp_rx_t;

  typedef struct packed {
    cfp_status_e        frame_status;
    logic [ANGLE_W-1:0] angle;
  } cfp_res_t;

  // frame bytes that are read when the frame completes
  typedef struct packed {
    logic [7:0] hdr1;
    logic [7:0] hundreds;
    logic [7:0] tens;
    logic [7:0] units;
    logic [7:0] tenths;
  } cfp_frame_t;

endpackage

// ===== src/cfp_stream_if.sv =====
// ---------------------------------------------------------------------------
// compass frame parser stream channel
// valid/ready channel carrying one payload of a chosen type
// ---------------------------------------------------------------------------
interface cfp_stream_if #(
  parameter type payload_t = logic [7:0]
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

// ===== src/cfp_frame_check.sv =====
// ---------------------------------------------------------------------------
// compass frame check
// header and checksum test of a complete frame, angle from digit nibbles
// ---------------------------------------------------------------------------
module cfp_frame_check import cfp_pkg::*; (
  input  cfp_frame_t frame_i,
  input  logic [7:0] sum_byte_i,
  output cfp_res_t   res_o
);

  logic [7:0]         sum;
  logic [3:0]         hund_nib;
  logic [3:0]         tens_nib;
  logic [3:0]         unit_nib;
  logic [ANGLE_W-1:0] angle;

  // checksum wraps at 8 bits
  assign sum = SUM_BASE + frame_i.hundreds + frame_i.tens + frame_i.units + frame_i.tenths;

  assign hund_nib = frame_i.hundreds[3:0] & NIBBLE_MASK;
  assign tens_nib = frame_i.tens[3:0] & NIBBLE_MASK;
  assign unit_nib = frame_i.units[3:0] & NIBBLE_MASK;

  assign angle = ANGLE_W'(hund_nib) * ANGLE_W'(100)
               + ANGLE_W'(tens_nib) * ANGLE_W'(10)
               + ANGLE_W'(unit_nib);

  always_comb begin
    res_o.frame_status = STATUS_GOOD;
    res_o.angle        = angle;
    if (frame_i.hdr1 != HDR1) begin
      res_o.frame_status = STATUS_BAD_HDR;
      res_o.angle        = '0;
    end else if (sum != sum_byte_i) begin
      res_o.frame_status = STATUS_BAD_SUM;
      res_o.angle        = '0;
    end
  end

endmodule

// ===== src/compass_frame_parser_top.sv =====
// ---------------------------------------------------------------------------
// compass frame parser
// assembles 8-byte compass frames from received bytes, one status per frame
// ---------------------------------------------------------------------------
//   port    dir  payload                 moves
//   rx_i    in   rx_byte[7:0]            one received byte per request
//   res_o   out  frame_status, angle     one status per completed frame
//
// a byte passes an input register and the frame logic, its status (if any)
// is loaded into the output register after the request is taken
// one byte per cycle sustained while rx_i does not stall, set by the single count/store update
// rx_i stalls only when a frame completes while the output register holds
// a status that is not taken in that cycle
// reset clears the byte count and both valid flags, frame bytes need none
// ---------------------------------------------------------------------------
`include "compass_frame_parser_top_defines.svh"

module compass_frame_parser_top import cfp_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  cfp_stream_if.sink   rx_i,
  cfp_stream_if.source res_o
);

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic [2:0] count_q, count_d;
  cfp_frame_t frame_q, frame_d;
  logic       out_valid_q;
  cfp_res_t   out_res_q;
  cfp_res_t   check_res;

  logic is_last;
  logic out_free;
  logic advance;
  logic rx_ready;
  logic rx_accept;

  assign is_last   = (count_q == POS_SUM);
  assign out_free  = !out_valid_q || res_o.ready;
  assign advance   = in_valid_q && (!is_last || out_free);
  assign rx_ready  = !in_valid_q || advance;
  assign rx_accept = rx_i.valid && rx_ready;

  assign rx_i.ready    = rx_ready;
  assign res_o.valid   = out_valid_q;
  assign res_o.payload = out_res_q;

  cfp_frame_check u_check (
    .frame_i    (frame_q),
    .sum_byte_i (in_byte_q),
    .res_o      (check_res)
  );

  always_comb begin
    count_d = count_q;
    frame_d = frame_q;
    if (advance) begin
      if (is_last) begin
        count_d = POS_HDR0;
      end else if (count_q == POS_HDR0 && in_byte_q != HDR0) begin
        // drop bytes until a frame start shows up
        count_d = POS_HDR0;
      end else begin
        count_d = count_q + 3'd1;
        case (count_q)
          POS_HDR1:     frame_d.hdr1     = in_byte_q;
          POS_HUNDREDS: frame_d.hundreds = in_byte_q;
          POS_TENS:     frame_d.tens     = in_byte_q;
          POS_UNITS:    frame_d.units    = in_byte_q;
          POS_TENTHS:   frame_d.tenths   = in_byte_q;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      count_q     <= POS_HDR0;
      out_valid_q <= 1'b0;
    end else begin
      if (rx_ready) begin
        in_valid_q <= rx_i.valid;
      end
      count_q <= count_d;
      if (advance && is_last) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_accept) begin
      in_byte_q <= rx_i.payload.rx_byte;
    end
    frame_q <= frame_d;
    if (advance && is_last) begin
      out_res_q <= check_res;
    end
  end

  `CFP_ASSERT_NEXT(a_count_wraps, clk_i, rst_ni, advance && is_last, count_q == POS_HDR0,
    "byte count did not return to zero after a frame")

  `CFP_ASSERT_NEXT(a_bad_start_dropped, clk_i, rst_ni,
    advance && count_q == POS_HDR0 && in_byte_q != HDR0, count_q == POS_HDR0,
    "bad start byte advanced the byte count")

  `CFP_ASSERT_NOW(a_angle_zero_on_error, clk_i, rst_ni,
    out_valid_q && out_res_q.frame_status != STATUS_GOOD, out_res_q.angle == '0,
    "error status carries a nonzero angle")

  `CFP_ASSERT_NOW(a_angle_range, clk_i, rst_ni, out_valid_q, out_res_q.angle <= ANGLE_MAX,
    "angle out of range")

endmodule
